// ===== hdl/sit_pkg.sv =====
// Package for the sorted id table: operation and status codes, transaction structs,
// and the sequencer state type. No dependencies.
package sit_pkg;

  typedef enum logic [3:0] {
    OP_INSERT       = 4'd0,
    OP_APPEND       = 4'd1,
    OP_REMOVE_FIRST = 4'd2,
    OP_REMOVE_KEY   = 4'd3,
    OP_GET_FIRST    = 4'd4,
    OP_GET_AT       = 4'd5,
    OP_INDEX_OF_KEY = 4'd6,
    OP_KEY_OF_ID    = 4'd7,
    OP_ID_OF_KEY    = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_MISS   = 3'd1,
    ST_FULL   = 3'd2,
    ST_DUP    = 3'd3,
    ST_BADIDX = 3'd4
  } status_t;

  typedef struct packed {
    logic [3:0]  operation;
    logic [31:0] req_key;
    logic [31:0] req_id;
    logic [5:0]  req_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_key;
    logic [31:0] found_id;
    logic [5:0]  found_index;
    logic [6:0]  entry_total;
  } rsp_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_FETCH,
    S_DONE
  } state_t;

endpackage

// ===== hdl/sit_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/sorted_id_table_with_key_map_core.sv =====
// Sorted (id, key) table top level: request sequencer and two entry memories.
// Depends on sit_pkg and sit_ram.
//
// Usage: requests arrive on in_valid/in_ready carrying an operation and its
// operands; one response leaves per request on out_valid/out_ready with a
// status, the addressed entry and the entry count after the operation.
// The entries live in two RAMs (ids, keys) with registered reads.
// Every operation that searches (insert, append, remove_key, lookups) scans
// a non-empty table one entry a cycle. Insert and removal then move the
// entries above the position one slot at a time, each move being a read
// then a write through the single memory port pair. get_first,
// remove_first's read and get_at use a single addressed read. One request
// is in flight at a time; the response sits in an output register, and the
// next request is accepted while it waits to be taken. Reset clears the
// entry count and the control state, not the memories; no clearing pass is
// needed. A stalled receiver holds the response and the block stops taking
// requests once the output register is occupied and a new result is ready.
module sorted_id_table_with_key_map_core #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sit_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sit_pkg::rsp_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Request and working registers
  sit_pkg::state_t state_r, state_nxt;
  sit_pkg::req_t   req_r, req_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [CW-1:0]   ptr_r, ptr_nxt;       // address issued last cycle while scanning or fetching
  logic            rdv_r, rdv_nxt;       // read data of the issued read valid this cycle
  logic            kdup_r, kdup_nxt;
  logic            idup_r, idup_nxt;
  logic            pos_ok_r, pos_ok_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic            hit_r, hit_nxt;
  logic [31:0]     hkey_r, hkey_nxt, hid_r, hid_nxt;
  logic [2:0]      st_r, st_nxt;
  sit_pkg::rsp_t   out_r, out_nxt;
  logic            ov_r, ov_nxt;

  // Memory ports
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [31:0]   wid, wkey, rid, rkey;

  sit_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_id_ram (
    .clk(clk), .wr_en(we), .wr_addr(wa), .wr_data(wid), .rd_addr(ra), .rd_data(rid));
  sit_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_key_ram (
    .clk(clk), .wr_en(we), .wr_addr(wa), .wr_data(wkey), .rd_addr(ra), .rd_data(rkey));

  logic [CW-1:0] idx_ext;
  logic          idx_bad;
  assign idx_ext = CW'(in_data.req_index);
  // compared at full width so a small table does not fold the index
  assign idx_bad = (32'(in_data.req_index) >= 32'(fill_r));

  assign in_ready  = (state_r == sit_pkg::S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = out_r;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    fill_nxt   = fill_r;
    ptr_nxt    = ptr_r;
    rdv_nxt    = 1'b0;
    kdup_nxt   = kdup_r;
    idup_nxt   = idup_r;
    pos_ok_nxt = pos_ok_r;
    pos_nxt    = pos_r;
    hit_nxt    = hit_r;
    hkey_nxt   = hkey_r;
    hid_nxt    = hid_r;
    st_nxt     = st_r;
    out_nxt    = out_r;
    ov_nxt     = ov_r && !out_ready;
    we         = 1'b0;
    wa         = '0;
    wid        = '0;
    wkey       = '0;
    ra         = ptr_r[AW-1:0];

    case (state_r)
      sit_pkg::S_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data;
          kdup_nxt   = 1'b0;
          idup_nxt   = 1'b0;
          pos_ok_nxt = 1'b0;
          hit_nxt    = 1'b0;
          pos_nxt    = fill_r;
          ptr_nxt    = '0;
          ra         = '0;
          st_nxt     = sit_pkg::ST_MISS;
          case (in_data.operation)
            sit_pkg::OP_INSERT, sit_pkg::OP_APPEND, sit_pkg::OP_REMOVE_KEY,
            sit_pkg::OP_INDEX_OF_KEY, sit_pkg::OP_KEY_OF_ID,
            sit_pkg::OP_ID_OF_KEY: begin
              if (fill_r != '0) begin
                rdv_nxt   = 1'b1;
                state_nxt = sit_pkg::S_SCAN;
              end else if (in_data.operation == sit_pkg::OP_INSERT ||
                           in_data.operation == sit_pkg::OP_APPEND) begin
                // Empty table: nothing to compare, the pair goes to slot zero
                st_nxt    = sit_pkg::ST_OK;
                hkey_nxt  = in_data.req_key;
                hid_nxt   = in_data.req_id;
                state_nxt = sit_pkg::S_SHIFT_UP;
              end else begin
                state_nxt = sit_pkg::S_DONE;
              end
            end
            sit_pkg::OP_REMOVE_FIRST, sit_pkg::OP_GET_FIRST: begin
              if (fill_r != '0) begin
                rdv_nxt   = 1'b1;
                state_nxt = sit_pkg::S_FETCH;
              end else begin
                state_nxt = sit_pkg::S_DONE;
              end
            end
            sit_pkg::OP_GET_AT: begin
              if (fill_r == '0) begin
                state_nxt = sit_pkg::S_DONE;
              end else if (idx_bad) begin
                st_nxt    = sit_pkg::ST_BADIDX;
                state_nxt = sit_pkg::S_DONE;
              end else begin
                ptr_nxt   = idx_ext;
                ra        = AW'(in_data.req_index);
                rdv_nxt   = 1'b1;
                state_nxt = sit_pkg::S_FETCH;
              end
            end
            default: state_nxt = sit_pkg::S_DONE;
          endcase
        end
      end

      // One entry compared per cycle; next address issued alongside
      sit_pkg::S_SCAN: begin
        if (rkey == req_r.req_key) begin
          kdup_nxt = 1'b1;
        end
        if (rid == req_r.req_id) begin
          idup_nxt = 1'b1;
        end
        // insert position: first entry with a greater id
        if (req_r.operation == sit_pkg::OP_INSERT && !pos_ok_r && rid > req_r.req_id) begin
          pos_ok_nxt = 1'b1;
          pos_nxt    = ptr_r;
        end
        // first match for lookups
        if (!hit_r) begin
          if (((req_r.operation == sit_pkg::OP_KEY_OF_ID) && rid == req_r.req_id) ||
              ((req_r.operation != sit_pkg::OP_KEY_OF_ID) && rkey == req_r.req_key)) begin
            hit_nxt  = 1'b1;
            hkey_nxt = rkey;
            hid_nxt  = rid;
            if (!(req_r.operation == sit_pkg::OP_INSERT ||
                  req_r.operation == sit_pkg::OP_APPEND)) begin
              pos_nxt = ptr_r;
            end
          end
        end
        if (ptr_r + CW'(1) < fill_r) begin
          ptr_nxt = ptr_r + CW'(1);
          ra      = ptr_nxt[AW-1:0];
          rdv_nxt = 1'b1;
        end else begin
          state_nxt = sit_pkg::S_DONE;
          if (req_r.operation == sit_pkg::OP_INSERT ||
              req_r.operation == sit_pkg::OP_APPEND) begin
            if (kdup_nxt || idup_nxt) begin
              st_nxt = sit_pkg::ST_DUP;
            end else if (fill_r >= CW'(CAPACITY)) begin
              st_nxt = sit_pkg::ST_FULL;
            end else begin
              if (req_r.operation == sit_pkg::OP_APPEND) begin
                pos_nxt = fill_r;
              end
              st_nxt = sit_pkg::ST_OK;
              hkey_nxt = req_r.req_key;
              hid_nxt  = req_r.req_id;
              // Shift entries at pos and above up, starting from the top
              ptr_nxt   = fill_r;
              state_nxt = sit_pkg::S_SHIFT_UP;
            end
          end else if (hit_nxt) begin
            st_nxt = sit_pkg::ST_OK;
            if (req_r.operation == sit_pkg::OP_REMOVE_KEY) begin
              ptr_nxt   = pos_nxt;
              state_nxt = sit_pkg::S_SHIFT_DN;
            end
          end
        end
      end

      // ptr_r is the slot being filled; read slot below, write next cycle
      sit_pkg::S_SHIFT_UP: begin
        if (rdv_r) begin
          we      = 1'b1;
          wa      = ptr_r[AW-1:0];
          wid     = rid;
          wkey    = rkey;
          ptr_nxt = ptr_r - CW'(1);
        end else if (ptr_r == pos_r) begin
          we        = 1'b1;
          wa        = ptr_r[AW-1:0];
          wid       = req_r.req_id;
          wkey      = req_r.req_key;
          fill_nxt  = fill_r + CW'(1);
          state_nxt = sit_pkg::S_DONE;
        end else begin
          ra      = AW'(ptr_r - CW'(1));
          rdv_nxt = 1'b1;
        end
      end

      // ptr_r is the slot being overwritten by the one above it
      sit_pkg::S_SHIFT_DN: begin
        if (rdv_r) begin
          we      = 1'b1;
          wa      = ptr_r[AW-1:0];
          wid     = rid;
          wkey    = rkey;
          ptr_nxt = ptr_r + CW'(1);
        end else if (ptr_r + CW'(1) >= fill_r) begin
          fill_nxt  = fill_r - CW'(1);
          state_nxt = sit_pkg::S_DONE;
        end else begin
          ra      = AW'(ptr_r + CW'(1));
          rdv_nxt = 1'b1;
        end
      end

      // Single addressed read for first entry or get_at
      sit_pkg::S_FETCH: begin
        st_nxt   = sit_pkg::ST_OK;
        hit_nxt  = 1'b1;
        hkey_nxt = rkey;
        hid_nxt  = rid;
        pos_nxt  = ptr_r;
        if (req_r.operation == sit_pkg::OP_REMOVE_FIRST) begin
          state_nxt = sit_pkg::S_SHIFT_DN;
        end else begin
          state_nxt = sit_pkg::S_DONE;
        end
      end

      sit_pkg::S_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          out_nxt.status      = st_r;
          out_nxt.entry_total = 7'(fill_r);
          if (st_r == sit_pkg::ST_OK) begin
            out_nxt.found_key   = hkey_r;
            out_nxt.found_id    = hid_r;
            out_nxt.found_index = 6'(pos_r);
          end else begin
            out_nxt.found_key   = '0;
            out_nxt.found_id    = '0;
            out_nxt.found_index = '0;
          end
          state_nxt = sit_pkg::S_IDLE;
        end
      end

      default: state_nxt = sit_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sit_pkg::S_IDLE;
      fill_r  <= '0;
      ov_r    <= 1'b0;
      rdv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ov_r    <= ov_nxt;
      rdv_r   <= rdv_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    ptr_r    <= ptr_nxt;
    kdup_r   <= kdup_nxt;
    idup_r   <= idup_nxt;
    pos_ok_r <= pos_ok_nxt;
    pos_r    <= pos_nxt;
    hit_r    <= hit_nxt;
    hkey_r   <= hkey_nxt;
    hid_r    <= hid_nxt;
    st_r     <= st_nxt;
    out_r    <= out_nxt;
  end

`ifndef ASSERT_OFF
  // Entry count never exceeds capacity
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // Count moves by at most one per transaction and only when leaving a shift
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_nxt != fill_r) |-> (state_r == sit_pkg::S_SHIFT_UP ||
                              state_r == sit_pkg::S_SHIFT_DN))
    else $error("entry count changed outside a shift");

  // A held response is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("response changed while stalled");
`endif

endmodule
